>>> hdl/sphere_pair_contact_macros.svh
// ----------------------------------------------------------------------------
// sphere_pair_contact_macros
// Assertion macros shared by the sphere pair contact block.
// ----------------------------------------------------------------------------
`ifndef SPHERE_PAIR_CONTACT_MACROS_SVH
`define SPHERE_PAIR_CONTACT_MACROS_SVH

// same-cycle implication, gated off during reset
`define SPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, gated off during reset
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Types and constants shared by the sphere pair contact block.
// ----------------------------------------------------------------------------
package spc_pkg;

	// queue between front and back
	localparam int SPC_QUEUE_DEPTH  = 8;
	// register stages in the front, all counted as in flight for the queue
	localparam int SPC_FRONT_STAGES = 4;
	// square root steps for the distance and for the grip product
	localparam int SPC_ROOT_STEPS   = 32;
	localparam int SPC_GRIP_STEPS   = 16;
	// quotient bits for each normal component
	localparam int SPC_DIV_STEPS    = 16;
	// reset value of the near-zero distance register
	localparam logic [15:0] SPC_NEAR_RESET = 16'd1;

	// one sphere pair
	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
		logic [30:0]        first_radius;
		logic [30:0]        second_radius;
		logic [15:0]        first_bounce;
		logic [15:0]        second_bounce;
		logic [15:0]        first_grip;
		logic [15:0]        second_grip;
	} pair_t;

	// one contact result
	typedef struct packed {
		logic               hit;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [31:0]        depth;
		logic signed [31:0] touch_x;
		logic signed [31:0] touch_y;
		logic signed [31:0] touch_z;
		logic [15:0]        mixed_bounce;
		logic [15:0]        mixed_grip;
	} contact_t;

	// classified item handed from front to back
	typedef struct packed {
		logic             hit;
		logic [63:0]      dsq;
		logic [31:0]      rs;
		logic [30:0]      r1;
		logic [2:0][31:0] base;
		logic [2:0]       dneg;
		logic [2:0][31:0] dmag;
		logic [15:0]      bounce;
		logic [31:0]      gprod;
	} job_t;

	// queue status seen by the top level
	typedef struct packed {
		logic push;
		logic empty;
		logic full;
		logic almost_full;
	} qstat_t;

endpackage

>>> hdl/sphere_pair_contact.sv
// ----------------------------------------------------------------------------
// sphere_pair_contact
// Sphere pair overlap test with normal, depth, contact point and materials.
// ----------------------------------------------------------------------------
//  channel   signals              direction  handshake
//  pair      start, busy, pair    in         taken when start and not busy
//  contact   done, contact        out        one cycle per result, no stall
//  config    cfg_we, cfg_data     in         written when cfg_we is high
//
//  One pair per cycle sustained while busy is low; every item gives one result.
//  The back holds the 32-step distance root and the 16-step normal
//  division, one step per pipeline stage.
//  Reset clears all valid bits and loads the near-zero distance with 1.
//  busy rises only when the front-to-back queue cannot take the front's
//  in-flight items; the receiver cannot stall, so in practice it stays low.
// ----------------------------------------------------------------------------
`include "sphere_pair_contact_macros.svh"

module sphere_pair_contact import spc_pkg::*; #(
	parameter int QUEUE_DEPTH = SPC_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pair_t       pair,
	output logic        done,
	output contact_t    contact,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);

	logic        near_q;
	logic [15:0] near_zero_q;
	logic        f_valid;
	job_t        f_item;
	logic        q_valid;
	job_t        q_item;
	qstat_t      q_stat;

	// near-zero distance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_zero_q <= SPC_NEAR_RESET;
		end else if (cfg_we) begin
			near_zero_q <= cfg_data;
		end
	end

	// registered queue-full flag, ORed into busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= 1'b0;
		end else begin
			near_q <= q_stat.full;
		end
	end

	assign busy = q_stat.almost_full | near_q;

	spc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (start & ~busy),
		.pair      (pair),
		.out_valid (f_valid),
		.out_item  (f_item)
	);

	spc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.push_item (f_item),
		.pop_valid (q_valid),
		.pop_item  (q_item),
		.stat      (q_stat)
	);

	spc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_item   (q_item),
		.near_zero (near_zero_q),
		.done      (done),
		.contact   (contact)
	);

	// checks
	`SPC_ASSERT_NOW(a_no_overflow, clk, arst_n, q_stat.push, !q_stat.full, "queue overflow")
	`SPC_ASSERT_NOW(a_hit_depth, clk, arst_n, done && contact.hit, contact.depth != 32'd0, "hit with zero depth")
	`SPC_ASSERT_NEXT(a_empty_stays, clk, arst_n, q_stat.empty && !q_stat.push, q_stat.empty, "queue filled without push")

endmodule

>>> hdl/spc_front.sv
// ----------------------------------------------------------------------------
// spc_front
// Accepts sphere pairs, squares the centre distance and classifies hit/miss.
// ----------------------------------------------------------------------------
module spc_front import spc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  pair_t pair,
	output logic  out_valid,
	output job_t  out_item
);

	logic             v_s1, v_s2, v_s3, v_s4;
	job_t             job_s1, job_s2, job_s3, job_s4;
	job_t             j2_n, j3_n, j4_n;
	logic [2:0][63:0] sq_s2;
	logic [63:0]      rs2_s2, rs2_s3;
	logic [1:0]       over_s3;

	logic [2:0][32:0] diff, ndiff;
	logic [2:0][31:0] c1, c2;
	logic [16:0]      bsum;
	logic [65:0]      dsq_full;

	// per-axis difference and magnitude
	always_comb begin
		c1 = {pair.first_z, pair.first_y, pair.first_x};
		c2 = {pair.second_z, pair.second_y, pair.second_x};
		for (int i = 0; i < 3; i++) begin
			diff[i]  = {c2[i][31], c2[i]} - {c1[i][31], c1[i]};
			ndiff[i] = -diff[i];
		end
		bsum = {1'b0, pair.first_bounce} + {1'b0, pair.second_bounce};
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: differences, radius sum, mean restitution
	always_ff @(posedge clk) begin
		job_s1.hit    <= 1'b0;
		job_s1.dsq    <= '0;
		job_s1.rs     <= {1'b0, pair.first_radius} + {1'b0, pair.second_radius};
		job_s1.r1     <= pair.first_radius;
		job_s1.base   <= c1;
		job_s1.bounce <= bsum[16:1];
		// grip pair held packed until the product is formed
		job_s1.gprod  <= {pair.first_grip, pair.second_grip};
		for (int i = 0; i < 3; i++) begin
			job_s1.dneg[i] <= diff[i][32];
			job_s1.dmag[i] <= diff[i][32] ? ndiff[i][31:0] : diff[i][31:0];
		end
	end

	// stage 2: squares and products
	always_comb begin
		j2_n       = job_s1;
		j2_n.gprod = {16'b0, job_s1.gprod[31:16]} * {16'b0, job_s1.gprod[15:0]};
	end

	always_ff @(posedge clk) begin
		job_s2 <= j2_n;
		rs2_s2 <= {32'b0, job_s1.rs} * {32'b0, job_s1.rs};
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= {32'b0, job_s1.dmag[i]} * {32'b0, job_s1.dmag[i]};
		end
	end

	// stage 3: squared distance sum with overflow bits
	assign dsq_full = {2'b0, sq_s2[0]} + {2'b0, sq_s2[1]} + {2'b0, sq_s2[2]};

	always_comb begin
		j3_n     = job_s2;
		j3_n.dsq = dsq_full[63:0];
	end

	always_ff @(posedge clk) begin
		job_s3  <= j3_n;
		over_s3 <= dsq_full[65:64];
		rs2_s3  <= rs2_s2;
	end

	// stage 4: overlap test
	always_comb begin
		j4_n     = job_s3;
		j4_n.hit = (over_s3 == 2'b00) && (job_s3.dsq < rs2_s3);
	end

	always_ff @(posedge clk) begin
		job_s4 <= j4_n;
	end

	assign out_valid = v_s4;
	assign out_item  = job_s4;

endmodule

>>> hdl/spc_queue.sv
// ----------------------------------------------------------------------------
// spc_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module spc_queue import spc_pkg::*; #(
	parameter int DEPTH = SPC_QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  job_t   push_item,
	output logic   pop_valid,
	output job_t   pop_item,
	output qstat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] LIMIT = CW'(DEPTH - SPC_FRONT_STAGES);
	localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic          valid_q;
	job_t          item_q;

	// back always drains, so pop whenever something is stored
	assign pop = (count_q != '0);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
			valid_q <= pop;
		end
	end

	// storage, read into an output register
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
		if (pop) begin
			item_q <= mem_q[rd_q];
		end
	end

	assign pop_valid        = valid_q;
	assign pop_item         = item_q;
	assign stat.push        = push;
	assign stat.empty       = (count_q == '0);
	assign stat.full        = (count_q == CW'(DEPTH));
	assign stat.almost_full = (count_q >= LIMIT);

endmodule

>>> hdl/spc_back.sv
// ----------------------------------------------------------------------------
// spc_back
// Square roots, normal division and contact point for classified items.
// ----------------------------------------------------------------------------
module spc_back import spc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  job_t        in_item,
	input  logic [15:0] near_zero,
	output logic        done,
	output contact_t    contact
);

	typedef struct packed {
		job_t        job;
		logic [63:0] rem;
		logic [63:0] res;
		logic [31:0] grem;
		logic [31:0] gres;
	} root_t;

	typedef struct packed {
		logic             hit;
		logic [2:0]       dneg;
		logic [2:0][31:0] base;
		logic [15:0]      bounce;
		logic [15:0]      groot;
		logic [31:0]      span;
		logic [31:0]      depth;
		logic             near;
		logic [32:0]      off;
		logic [2:0][47:0] rem;
		logic [2:0][15:0] q;
	} div_t;

	typedef struct packed {
		logic             hit;
		logic [2:0][31:0] base;
		logic [15:0]      bounce;
		logic [15:0]      groot;
		logic [31:0]      depth;
		logic [32:0]      off;
		logic [2:0][15:0] n;
	} nrm_t;

	root_t            root_s [SPC_ROOT_STEPS + 1];
	logic             root_v [SPC_ROOT_STEPS + 1];
	div_t             div_s  [SPC_DIV_STEPS + 1];
	logic             div_v  [SPC_DIV_STEPS + 1];
	nrm_t             nrm_s7;
	logic             nrm_v;
	nrm_t             mul_s8;
	logic [2:0][48:0] prod_s8;
	logic             mul_v;
	logic             done_q;
	contact_t         contact_q;

	// entry into the root pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_v[0] <= 1'b0;
		end else begin
			root_v[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		root_s[0].job  <= in_item;
		root_s[0].rem  <= in_item.dsq;
		root_s[0].res  <= '0;
		root_s[0].grem <= in_item.gprod;
		root_s[0].gres <= '0;
	end

	// one distance root bit per stage; the grip root takes a bit only in the first SPC_GRIP_STEPS stages
	for (genvar k = 1; k <= SPC_ROOT_STEPS; k++) begin : g_root
		localparam logic [63:0] RBIT = 64'd1 << (2 * (SPC_ROOT_STEPS - k));
		localparam int          GSH  = (k <= SPC_GRIP_STEPS) ? 2 * (SPC_GRIP_STEPS - k) : 0;
		localparam logic [31:0] GBIT = 32'd1 << GSH;
		logic [63:0] rtry;
		logic [31:0] gtry;
		root_t       nxt;

		always_comb begin
			nxt  = root_s[k-1];
			rtry = root_s[k-1].res + RBIT;
			gtry = root_s[k-1].gres + GBIT;
			if (root_s[k-1].rem >= rtry) begin
				nxt.rem = root_s[k-1].rem - rtry;
				nxt.res = (root_s[k-1].res >> 1) + RBIT;
			end else begin
				nxt.res = root_s[k-1].res >> 1;
			end
			if (k <= SPC_GRIP_STEPS) begin
				if (root_s[k-1].grem >= gtry) begin
					nxt.grem = root_s[k-1].grem - gtry;
					nxt.gres = (root_s[k-1].gres >> 1) + GBIT;
				end else begin
					nxt.gres = root_s[k-1].gres >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				root_v[k] <= 1'b0;
			end else begin
				root_v[k] <= root_v[k-1];
			end
		end

		always_ff @(posedge clk) begin
			root_s[k] <= nxt;
		end
	end

	// depth, offset and dividends from the distance
	logic [31:0] p_dist, p_depth;
	div_t        p_div;

	always_comb begin
		p_dist         = root_s[SPC_ROOT_STEPS].res[31:0];
		p_depth        = root_s[SPC_ROOT_STEPS].job.rs - p_dist;
		p_div.hit      = root_s[SPC_ROOT_STEPS].job.hit;
		p_div.dneg     = root_s[SPC_ROOT_STEPS].job.dneg;
		p_div.base     = root_s[SPC_ROOT_STEPS].job.base;
		p_div.bounce   = root_s[SPC_ROOT_STEPS].job.bounce;
		p_div.groot    = root_s[SPC_ROOT_STEPS].gres[15:0];
		p_div.span     = p_dist;
		p_div.depth    = p_depth;
		p_div.near     = (p_dist <= {16'b0, near_zero});
		p_div.off      = {2'b00, root_s[SPC_ROOT_STEPS].job.r1} - {2'b00, p_depth[31:1]};
		p_div.q        = '0;
		for (int i = 0; i < 3; i++) begin
			p_div.rem[i] = ({16'b0, root_s[SPC_ROOT_STEPS].job.dmag[i]} << 15)
			             + {17'b0, p_dist[31:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v[0] <= 1'b0;
		end else begin
			div_v[0] <= root_v[SPC_ROOT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		div_s[0] <= p_div;
	end

	// restoring division, one quotient bit per stage on three lanes
	for (genvar j = 1; j <= SPC_DIV_STEPS; j++) begin : g_div
		localparam int SH = SPC_DIV_STEPS - j;
		logic [47:0] cmp;
		div_t        nxt;

		always_comb begin
			nxt = div_s[j-1];
			cmp = {16'b0, div_s[j-1].span} << SH;
			for (int i = 0; i < 3; i++) begin
				if (div_s[j-1].rem[i] >= cmp) begin
					nxt.rem[i]   = div_s[j-1].rem[i] - cmp;
					nxt.q[i][SH] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v[j] <= 1'b0;
			end else begin
				div_v[j] <= div_v[j-1];
			end
		end

		always_ff @(posedge clk) begin
			div_s[j] <= nxt;
		end
	end

	// signed, saturated normal with the near-zero fallback
	nrm_t  n_next;
	div_t  d_last;
	logic [15:0] nq;

	always_comb begin
		d_last        = div_s[SPC_DIV_STEPS];
		n_next.hit    = d_last.hit;
		n_next.base   = d_last.base;
		n_next.bounce = d_last.bounce;
		n_next.groot  = d_last.groot;
		n_next.depth  = d_last.depth;
		n_next.off    = d_last.off;
		for (int i = 0; i < 3; i++) begin
			nq = d_last.q[i];
			if (d_last.dneg[i]) begin
				n_next.n[i] = (nq > 16'd32768) ? 16'h8000 : -nq;
			end else begin
				n_next.n[i] = (nq > 16'd32767) ? 16'h7FFF : nq;
			end
		end
		if (d_last.near) begin
			n_next.n[0] = 16'h7FFF;
			n_next.n[1] = '0;
			n_next.n[2] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_v  <= 1'b0;
			mul_v  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			nrm_v  <= div_v[SPC_DIV_STEPS];
			mul_v  <= nrm_v;
			done_q <= mul_v;
		end
	end

	// normal times offset
	always_ff @(posedge clk) begin
		nrm_s7 <= n_next;
		mul_s8 <= nrm_s7;
		for (int i = 0; i < 3; i++) begin
			prod_s8[i] <= {{33{nrm_s7.n[i][15]}}, nrm_s7.n[i]}
			            * {{16{nrm_s7.off[32]}}, nrm_s7.off};
		end
	end

	// rounded contact point, saturated, and the miss mask
	logic [2:0][48:0] pmag;
	logic [2:0][48:0] pround;
	logic [2:0][34:0] madd, tsum;
	logic [2:0][31:0] touch;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pmag[i]   = prod_s8[i][48] ? -prod_s8[i] : prod_s8[i];
			pround[i] = pmag[i] + 49'd16384;
			madd[i]   = {1'b0, pround[i][48:15]};
			tsum[i]   = {{3{mul_s8.base[i][31]}}, mul_s8.base[i]}
			          + (prod_s8[i][48] ? -madd[i] : madd[i]);
			if (!tsum[i][34] && (tsum[i][33:31] != 3'b000)) begin
				touch[i] = 32'h7FFF_FFFF;
			end else if (tsum[i][34] && (tsum[i][33:31] != 3'b111)) begin
				touch[i] = 32'h8000_0000;
			end else begin
				touch[i] = tsum[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_s8.hit) begin
			contact_q.hit          <= 1'b1;
			contact_q.normal_x     <= mul_s8.n[0];
			contact_q.normal_y     <= mul_s8.n[1];
			contact_q.normal_z     <= mul_s8.n[2];
			contact_q.depth        <= mul_s8.depth;
			contact_q.touch_x      <= touch[0];
			contact_q.touch_y      <= touch[1];
			contact_q.touch_z      <= touch[2];
			contact_q.mixed_bounce <= mul_s8.bounce;
			contact_q.mixed_grip   <= mul_s8.groot;
		end else begin
			contact_q <= '0;
		end
	end

	assign done    = done_q;
	assign contact = contact_q;

endmodule

>>> sim/sphere_pair_contact_tb.sv
// ----------------------------------------------------------------------------
// sphere_pair_contact_tb
// Drives sphere pairs into the contact block, predicts each contact result
// in fixed point and compares every field in order of arrival.
// ----------------------------------------------------------------------------
module sphere_pair_contact_tb;
	import spc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	// contact predictor and queue of expected contacts
	class contact_board;
		logic [15:0] near_dist;
		contact_t expected_q[$];
		int errors;

		function new();
			near_dist = SPC_NEAR_RESET;
			errors = 0;
		endfunction

		static function logic [63:0] root64(logic [63:0] v);
			logic [63:0] rem, res, b;
			rem = v;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (rem >= res + b) begin
					rem = rem - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		static function logic [63:0] absval(longint x);
			return x < 0 ? 64'(-x) : 64'(x);
		endfunction

		static function longint normal_of(longint d, logic [63:0] span);
			logic [63:0] q;
			q = ((absval(d) << 15) + (span >> 1)) / span;
			if (d < 0)
				return q > 32768 ? -32768 : -longint'(q);
			return q > 32767 ? 32767 : longint'(q);
		endfunction

		static function longint touch_of(longint base, longint n, longint off);
			longint p, t;
			logic [63:0] m;
			p = n * off;
			m = (absval(p) + 64'd16384) >> 15;
			t = base + (p < 0 ? -longint'(m) : longint'(m));
			if (t > 64'sd2147483647)
				t = 64'sd2147483647;
			if (t < -64'sd2147483648)
				t = -64'sd2147483648;
			return t;
		endfunction

		// note an accepted pair and queue its contact
		function void note_pair(pair_t p);
			contact_t c;
			longint fst[3], d[3], n[3], off;
			logic [63:0] dsq, sq, rs, span, depth;
			bit over;
			c = '0;
			fst[0] = longint'(p.first_x);
			fst[1] = longint'(p.first_y);
			fst[2] = longint'(p.first_z);
			d[0] = longint'(p.second_x) - fst[0];
			d[1] = longint'(p.second_y) - fst[1];
			d[2] = longint'(p.second_z) - fst[2];
			dsq = 0;
			over = 0;
			for (int i = 0; i < 3; i++) begin
				sq = absval(d[i]) * absval(d[i]);
				if (dsq + sq < dsq)
					over = 1;
				dsq = dsq + sq;
			end
			rs = 64'(p.first_radius) + 64'(p.second_radius);
			if (!over && dsq < rs * rs) begin
				span = root64(dsq);
				depth = rs - span;
				if (span <= 64'(near_dist)) begin
					n[0] = 32767; n[1] = 0; n[2] = 0;
				end else begin
					for (int i = 0; i < 3; i++)
						n[i] = normal_of(d[i], span);
				end
				off = longint'(p.first_radius) - longint'(depth >> 1);
				c.hit = 1'b1;
				c.normal_x = 16'(n[0]);
				c.normal_y = 16'(n[1]);
				c.normal_z = 16'(n[2]);
				c.depth = depth[31:0];
				c.touch_x = 32'(touch_of(fst[0], n[0], off));
				c.touch_y = 32'(touch_of(fst[1], n[1], off));
				c.touch_z = 32'(touch_of(fst[2], n[2], off));
				c.mixed_bounce = 16'((17'(p.first_bounce) + 17'(p.second_bounce)) >> 1);
				c.mixed_grip = 16'(root64(64'(p.first_grip) * 64'(p.second_grip)));
			end
			expected_q.push_back(c);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %0h want %0h", what, got, want);
			errors++;
		endtask

		// compare one arriving contact with the oldest expectation
		task check_contact(contact_t got);
			contact_t w;
			if (expected_q.size() == 0) begin
				report("unexpected contact", 64'(got.hit), 64'd0);
				return;
			end
			w = expected_q.pop_front();
			if (got.hit !== w.hit) report("hit", 64'(got.hit), 64'(w.hit));
			if (got.normal_x !== w.normal_x)
				report("normal_x", 64'(got.normal_x), 64'(w.normal_x));
			if (got.normal_y !== w.normal_y)
				report("normal_y", 64'(got.normal_y), 64'(w.normal_y));
			if (got.normal_z !== w.normal_z)
				report("normal_z", 64'(got.normal_z), 64'(w.normal_z));
			if (got.depth !== w.depth) report("depth", 64'(got.depth), 64'(w.depth));
			if (got.touch_x !== w.touch_x)
				report("touch_x", 64'(got.touch_x), 64'(w.touch_x));
			if (got.touch_y !== w.touch_y)
				report("touch_y", 64'(got.touch_y), 64'(w.touch_y));
			if (got.touch_z !== w.touch_z)
				report("touch_z", 64'(got.touch_z), 64'(w.touch_z));
			if (got.mixed_bounce !== w.mixed_bounce)
				report("mixed_bounce", 64'(got.mixed_bounce), 64'(w.mixed_bounce));
			if (got.mixed_grip !== w.mixed_grip)
				report("mixed_grip", 64'(got.mixed_grip), 64'(w.mixed_grip));
		endtask
	endclass

	logic clk, arst_n, start, busy, done, cfg_we;
	logic [15:0] cfg_data;
	pair_t pair;
	contact_t contact;
	contact_board board;
	int idle_cycles;

	sphere_pair_contact dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pair(pair),
		.done(done), .contact(contact), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_contact(contact);
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// hand one pair to the block, holding start until taken
	task automatic send_pair(pair_t p, bit allow_gap);
		int g;
		g = allow_gap ? gap_len() : 0;
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
		start <= 1'b1;
		pair <= p;
		do @(posedge clk); while (busy);
		board.note_pair(p);
	endtask

	task automatic write_near(logic [15:0] v);
		start <= 1'b0;
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (70) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.near_dist = v;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			2: return 32'($signed($urandom_range(0, 400)) - 200);
			default: return 32'($signed($urandom_range(0, 60000000)) - 30000000);
		endcase
	endfunction

	// mostly near or overlapping pairs with random content
	function automatic pair_t rand_pair();
		pair_t p;
		int mode;
		mode = $urandom_range(0, 9);
		p.first_x = rand_coord();
		p.first_y = rand_coord();
		p.first_z = rand_coord();
		if (mode < 7) begin
			int s;
			s = mode < 2 ? 300 : (mode < 5 ? 3000000 : 200000000);
			p.second_x = p.first_x + ($signed($urandom_range(0, 2 * s)) - s);
			p.second_y = p.first_y + ($signed($urandom_range(0, 2 * s)) - s);
			p.second_z = p.first_z + ($signed($urandom_range(0, 2 * s)) - s);
			p.first_radius = 31'($urandom_range(0, 2 * s));
			p.second_radius = 31'($urandom_range(0, 2 * s));
		end else begin
			p.second_x = $urandom;
			p.second_y = $urandom;
			p.second_z = $urandom;
			p.first_radius = 31'($urandom);
			p.second_radius = 31'($urandom);
		end
		if ($urandom_range(0, 19) == 0) p.first_radius = 31'h7fffffff;
		if ($urandom_range(0, 19) == 0) p.second_radius = 31'h7fffffff;
		p.first_bounce = 16'($urandom);
		p.second_bounce = 16'($urandom);
		p.first_grip = 16'($urandom);
		p.second_grip = 16'($urandom);
		return p;
	endfunction

	function automatic pair_t mk(int fx, int fy, int fz, int sx, int sy, int sz,
			int r1, int r2);
		pair_t p;
		p.first_x = fx; p.first_y = fy; p.first_z = fz;
		p.second_x = sx; p.second_y = sy; p.second_z = sz;
		p.first_radius = 31'(r1); p.second_radius = 31'(r2);
		p.first_bounce = 16'($urandom); p.second_bounce = 16'($urandom);
		p.first_grip = 16'($urandom); p.second_grip = 16'($urandom);
		return p;
	endfunction

	initial begin
		pair_t p;
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		pair = '0;
		idle_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: misses, coincident centres, extremes, saturation
		send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0), 0);
		send_pair(mk(0, 0, 0, 0, 0, 0, 65536, 65536), 0);
		send_pair(mk(0, 0, 0, 1, 0, 0, 10, 10), 0);
		send_pair(mk(0, 0, 0, 0, 2, 0, 10, 10), 0);
		send_pair(mk(0, 0, 0, 65536, 0, 0, 65536, 65536), 0);
		send_pair(mk(0, 0, 0, -65536, 0, 0, 65536, 65536), 0);
		send_pair(mk(0, 0, 0, 0, 0, -131072, 65536, 131072), 0);
		send_pair(mk(0, 0, 0, 3, 3, 3, 10, 10), 0);
		send_pair(mk(0, 0, 0, 1, 1, 1, 2, 2), 0);
		send_pair(mk(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0);
		send_pair(mk(32'h7fffffff, 0, 0, 32'h7ffffff0, 0, 0, 32'h7fffffff, 32'h7fffffff), 0);
		send_pair(mk(32'h80000000, 0, 0, 32'h80000010, 0, 0, 32'h7fffffff, 32'h7fffffff), 0);
		send_pair(mk(32'h7fffffff, 5, -5, 32'h80000000, -5, 5, 32'h7fffffff, 32'h7fffffff), 0);
		send_pair(mk(100, 200, 300, 100, 200, 300, 31'h7fffffff, 0), 0);
		p = mk(0, 0, 0, 5, 0, 0, 100, 100);
		p.first_bounce = 16'hffff; p.second_bounce = 16'hffff;
		p.first_grip = 16'hffff; p.second_grip = 16'hffff;
		send_pair(p, 0);
		p.first_bounce = '0; p.second_bounce = '0; p.first_grip = '0; p.second_grip = '0;
		send_pair(p, 0);

		write_near(16'd0);
		send_pair(mk(0, 0, 0, 0, 0, 0, 5, 5), 0);
		send_pair(mk(0, 0, 0, 1, 0, 0, 5, 5), 0);
		send_pair(mk(0, 0, 0, 0, -1, 0, 5, 5), 0);
		write_near(16'hffff);
		send_pair(mk(0, 0, 0, 0, 65535, 0, 100000, 100000), 0);
		send_pair(mk(0, 0, 0, 0, 0, 65536, 100000, 100000), 0);

		// random phases over several register settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_near(16'd1);
				1: write_near(16'd0);
				2: write_near(16'hffff);
				default: write_near(16'($urandom));
			endcase
			for (int i = 0; i < 210; i++)
				send_pair(rand_pair(), (ph % 2) == 0 || i > 100);
		end
		start <= 1'b0;

		// drain
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
